/* design/rpi_pkg.sv */
package rpi_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_NORMAL_X = 3'd3,
      REG_NORMAL_Y = 3'd4,
      REG_NORMAL_Z = 3'd5
   } reg_index_type;

   // Control that travels with an item from the dot products into the divider.
   typedef struct packed {
      logic valid;
      logic zero;
      logic neg;
   } div_ctl_type;

endpackage

/* design/rpi_dot.sv */
module rpi_dot #(
   parameter int W = rpi_pkg::WORD_BITS_DEF,
   parameter int F = rpi_pkg::FRAC_BITS_DEF,
   parameter int SW = 2*W + 3,
   parameter int DW = 2*W + 2,
   parameter int NW = SW + F
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic signed [W-1:0]    origin [3],
   input  logic signed [W-1:0]    dir [3],
   input  logic signed [W-1:0]    center [3],
   input  logic signed [W-1:0]    normal [3],
   output rpi_pkg::div_ctl_type   out_ctl,
   output logic [NW-1:0]          out_nabs,
   output logic [DW-1:0]          out_dabs,
   output logic [6*W-1:0]         out_side
);

   localparam int PW = 2*W + 1;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [W:0]    diff_ff [3];
   logic signed [PW-1:0] pn_ff [3];
   logic signed [2*W-1:0] pd_ff [3];
   logic signed [SW-1:0] num_ff;
   logic signed [DW-1:0] den_ff;
   logic signed [W-1:0]  dir1_ff [3];
   logic [6*W-1:0]       side1_ff, side2_ff, side3_ff, side4_ff;
   rpi_pkg::div_ctl_type ctl_ff;
   logic [NW-1:0]        nabs_ff;
   logic [DW-1:0]        dabs_ff;

   logic signed [SW-1:0] num_in;
   logic signed [DW-1:0] den_in;
   logic signed [SW-1:0] negnum;
   logic [SW-1:0]        nmag;
   logic [DW-1:0]        dmag;

   always_comb begin
      num_in = SW'(pn_ff[0]) + SW'(pn_ff[1]) + SW'(pn_ff[2]);
      den_in = DW'(pd_ff[0]) + DW'(pd_ff[1]) + DW'(pd_ff[2]);
      negnum = -num_ff;
      nmag = negnum[SW-1] ? SW'(-negnum) : SW'(negnum);
      dmag = den_ff[DW-1] ? DW'(-den_ff) : DW'(den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         ctl_ff <= '0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         ctl_ff.valid <= v3_ff;
         ctl_ff.zero <= (den_ff == '0);
         ctl_ff.neg <= negnum[SW-1] ^ den_ff[DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i] <= (W+1)'(origin[i]) - (W+1)'(center[i]);
            dir1_ff[i] <= dir[i];
            pn_ff[i] <= PW'(normal[i]) * PW'(diff_ff[i]);
            pd_ff[i] <= (2*W)'(normal[i]) * (2*W)'(dir1_ff[i]);
         end
         side1_ff <= {origin[0], origin[1], origin[2], dir[0], dir[1], dir[2]};
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         side4_ff <= side3_ff;
         num_ff <= num_in;
         den_ff <= den_in;
         nabs_ff <= {nmag, {F{1'b0}}};
         dabs_ff <= dmag;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_nabs = nabs_ff;
   assign out_dabs = dabs_ff;
   assign out_side = side4_ff;

endmodule

/* design/rpi_div.sv */
module rpi_div #(
   parameter int W = rpi_pkg::WORD_BITS_DEF,
   parameter int F = rpi_pkg::FRAC_BITS_DEF,
   parameter int DW = 2*W + 2,
   parameter int NW = 2*W + 3 + F
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  rpi_pkg::div_ctl_type in_ctl,
   input  logic [NW-1:0]        in_nabs,
   input  logic [DW-1:0]        in_dabs,
   input  logic [6*W-1:0]       in_side,
   output logic                 out_valid,
   output logic                 out_hit,
   output logic signed [W-1:0]  out_t,
   output logic [6*W-1:0]       out_side
);

   localparam int NHW = NW - W - 1;
   localparam int CW = (NHW > DW) ? NHW : DW;
   localparam int NS = W + 2;

   rpi_pkg::div_ctl_type ctl_ff [NS];
   logic                 ovf_ff [NS];
   logic [DW-1:0]        r_ff [NS];
   logic [W:0]           q_ff [NS];
   logic [NW-1:0]        n_ff [NS];
   logic [DW-1:0]        d_ff [NS];
   logic [6*W-1:0]       side_ff [NS];

   logic [CW-1:0]        nh;
   logic                 ovf0;

   assign nh = CW'(in_nabs[NW-1:W+1]);
   assign ovf0 = nh >= CW'(in_dabs);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ovf_ff[0] <= ovf0;
         r_ff[0] <= nh[DW-1:0];
         q_ff[0] <= '0;
         n_ff[0] <= in_nabs;
         d_ff[0] <= in_dabs;
         side_ff[0] <= in_side;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar s = 1; s < NS; s++) begin : g_step
      localparam int B = W - (s - 1);
      logic [DW:0] trial;
      logic        take;

      assign trial = {r_ff[s-1], n_ff[s-1][B]};
      assign take = trial >= {1'b0, d_ff[s-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (adv) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ovf_ff[s] <= ovf_ff[s-1];
            r_ff[s] <= take ? DW'(trial - {1'b0, d_ff[s-1]}) : trial[DW-1:0];
            q_ff[s] <= q_ff[s-1] | ((W+1)'(take) << B);
            n_ff[s] <= n_ff[s-1];
            d_ff[s] <= d_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   localparam logic [W:0] POS_LIM = {2'b00, {(W-1){1'b1}}};
   localparam logic [W:0] NEG_LIM = {2'b01, {(W-1){1'b0}}};
   localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

   rpi_pkg::div_ctl_type lc;
   logic [W:0]           ql;
   logic [W-1:0]         t_in;
   logic                 valid_ff, hit_ff;
   logic [W-1:0]         t_ff;
   logic [6*W-1:0]       oside_ff;

   always_comb begin
      lc = ctl_ff[NS-1];
      ql = q_ff[NS-1];
      if (lc.zero) begin
         t_in = '0;
      end else if (lc.neg) begin
         t_in = (ovf_ff[NS-1] || ql > NEG_LIM) ? SAT_MIN : W'(-ql);
      end else begin
         t_in = (ovf_ff[NS-1] || ql > POS_LIM) ? SAT_MAX : ql[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= lc.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= !lc.zero;
         t_ff <= t_in;
         oside_ff <= side_ff[NS-1];
      end
   end

   assign out_valid = valid_ff;
   assign out_hit = hit_ff;
   assign out_t = $signed(t_ff);
   assign out_side = oside_ff;

endmodule

/* design/rpi_point.sv */
module rpi_point #(
   parameter int W = rpi_pkg::WORD_BITS_DEF,
   parameter int F = rpi_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic                 in_hit,
   input  logic signed [W-1:0]  in_t,
   input  logic [6*W-1:0]       in_side,
   output logic                 out_valid,
   output logic                 out_hit,
   output logic signed [W-1:0]  out_t,
   output logic signed [W-1:0]  out_p [3]
);

   logic                  v1_ff, hit1_ff;
   logic signed [W-1:0]   t1_ff;
   logic signed [2*W-1:0] prod_ff [3];
   logic signed [W-1:0]   org1_ff [3];
   logic signed [W-1:0]   org0 [3];
   logic signed [W-1:0]   dir0 [3];

   logic                  v2_ff, hit2_ff;
   logic signed [W-1:0]   t2_ff;
   logic signed [W-1:0]   p2_ff [3];
   logic signed [W-1:0]   p_in [3];
   logic signed [2*W:0]   sum [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         org0[i] = $signed(in_side[(6-i)*W-1 -: W]);
         dir0[i] = $signed(in_side[(3-i)*W-1 -: W]);
         sum[i] = (2*W+1)'(prod_ff[i] >>> F) + (2*W+1)'(org1_ff[i]);
         if (!hit1_ff) begin
            p_in[i] = '0;
         end else if (sum[i][2*W:W-1] == '0 || sum[i][2*W:W-1] == '1) begin
            p_in[i] = sum[i][W-1:0];
         end else if (sum[i][2*W]) begin
            p_in[i] = {1'b1, {(W-1){1'b0}}};
         end else begin
            p_in[i] = {1'b0, {(W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit1_ff <= in_hit;
         t1_ff <= in_t;
         hit2_ff <= hit1_ff;
         t2_ff <= t1_ff;
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= (2*W)'(dir0[i]) * (2*W)'(in_t);
            org1_ff[i] <= org0[i];
            p2_ff[i] <= p_in[i];
         end
      end
   end

   assign out_valid = v2_ff;
   assign out_hit = hit2_ff;
   assign out_t = t2_ff;
   assign out_p = p2_ff;

endmodule

/* design/ray_plane_intersect.sv */
// Ray against plane intersection in signed fixed point (WORD_BITS wide, FRAC_BITS
// fraction bits). Each item is a ray; the result item carries hit, the ray
// parameter t and the hit point, all saturated to the word. The plane point and
// normal sit in six registers written through the csr_ port, which is always
// ready and should only be written while no item is in flight. The block is a
// fully pipelined datapath: one item is accepted every cycle while the pipeline
// is not held, and each item passes through 4 stages of dot products,
// WORD_BITS + 3 stages in the divider of which WORD_BITS + 1 each produce one
// quotient bit of a restoring division, and 2 stages for the hit point.
// The whole pipeline holds while a result waits under rsp_stall, so req_stall
// follows rsp_stall combinationally when the output register is occupied.
module ray_plane_intersect #(
   parameter int WORD_BITS = rpi_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [WORD_BITS-1:0]         req_origin_x,
   input  logic signed [WORD_BITS-1:0]         req_origin_y,
   input  logic signed [WORD_BITS-1:0]         req_origin_z,
   input  logic signed [WORD_BITS-1:0]         req_dir_x,
   input  logic signed [WORD_BITS-1:0]         req_dir_y,
   input  logic signed [WORD_BITS-1:0]         req_dir_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic signed [WORD_BITS-1:0]         rsp_distance_t,
   output logic signed [WORD_BITS-1:0]         rsp_hit_x,
   output logic signed [WORD_BITS-1:0]         rsp_hit_y,
   output logic signed [WORD_BITS-1:0]         rsp_hit_z,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rpi_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [WORD_BITS-1:0]                csr_data
);

   localparam int DW = 2*WORD_BITS + 2;
   localparam int NW = 2*WORD_BITS + 3 + FRAC_BITS;

   // Reset plane: y = -10 with normal +y.
   localparam logic [WORD_BITS-1:0] CY_RESET =
      WORD_BITS'(128'd0 - (128'd10 << FRAC_BITS));
   localparam logic [WORD_BITS-1:0] NY_RESET = WORD_BITS'(128'd1 << FRAC_BITS);

   logic signed [WORD_BITS-1:0] center_ff [3];
   logic signed [WORD_BITS-1:0] normal_ff [3];

   logic adv;

   // The pipeline moves whenever the output register is empty or being taken.
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= CY_RESET;
         center_ff[2] <= '0;
         normal_ff[0] <= '0;
         normal_ff[1] <= NY_RESET;
         normal_ff[2] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rpi_pkg::REG_CENTER_X: center_ff[0] <= csr_data;
            rpi_pkg::REG_CENTER_Y: center_ff[1] <= csr_data;
            rpi_pkg::REG_CENTER_Z: center_ff[2] <= csr_data;
            rpi_pkg::REG_NORMAL_X: normal_ff[0] <= csr_data;
            rpi_pkg::REG_NORMAL_Y: normal_ff[1] <= csr_data;
            rpi_pkg::REG_NORMAL_Z: normal_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   logic signed [WORD_BITS-1:0] origin [3];
   logic signed [WORD_BITS-1:0] dir [3];

   assign origin[0] = req_origin_x;
   assign origin[1] = req_origin_y;
   assign origin[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   rpi_pkg::div_ctl_type     dot_ctl;
   logic [NW-1:0]            dot_nabs;
   logic [DW-1:0]            dot_dabs;
   logic [6*WORD_BITS-1:0]   dot_side;

   rpi_dot #(.W(WORD_BITS), .F(FRAC_BITS)) u_dot (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .origin   (origin),
      .dir      (dir),
      .center   (center_ff),
      .normal   (normal_ff),
      .out_ctl  (dot_ctl),
      .out_nabs (dot_nabs),
      .out_dabs (dot_dabs),
      .out_side (dot_side)
   );

   logic                        div_valid, div_hit;
   logic signed [WORD_BITS-1:0] div_t;
   logic [6*WORD_BITS-1:0]      div_side;

   rpi_div #(.W(WORD_BITS), .F(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_ctl    (dot_ctl),
      .in_nabs   (dot_nabs),
      .in_dabs   (dot_dabs),
      .in_side   (dot_side),
      .out_valid (div_valid),
      .out_hit   (div_hit),
      .out_t     (div_t),
      .out_side  (div_side)
   );

   logic signed [WORD_BITS-1:0] pt [3];

   rpi_point #(.W(WORD_BITS), .F(FRAC_BITS)) u_point (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_hit    (div_hit),
      .in_t      (div_t),
      .in_side   (div_side),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_t     (rsp_distance_t),
      .out_p     (pt)
   );

   assign rsp_hit_x = pt[0];
   assign rsp_hit_y = pt[1];
   assign rsp_hit_z = pt[2];

endmodule
